// ===== rtl/core/pkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared types, codes and defaults of the keycode remap table core.
// ----------------------------------------------------------------------------
package pkrt_pkg;

   localparam int MAP_ENTRIES_DEF  = 256;
   localparam int ACTIVE_SLOTS_DEF = 8;
   localparam int LAYERS_DEF       = 16;
   localparam int COLUMNS_DEF      = 16;
   localparam int ROWS_DEF         = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NOOP_REMAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPARENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APP_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd3;

   localparam logic [1:0] OP_LOOKUP    = 2'd0;
   localparam logic [1:0] OP_WR_ENTRY  = 2'd1;
   localparam logic [1:0] OP_WR_SLOT   = 2'd2;
   localparam logic [1:0] OP_SET_COUNT = 2'd3;

   localparam logic [1:0] SRC_HIT   = 2'd0;
   localparam logic [1:0] SRC_FIXED = 2'd1;
   localparam logic [1:0] SRC_RANGE = 2'd2;
   localparam logic [1:0] SRC_MISS  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  layer;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [7:0]  index;
      logic [7:0]  app;
      logic [15:0] from_code;
      logic [15:0] to_code;
      logic [3:0]  count;
   } req_type;

   typedef struct packed {
      logic [15:0] keycode;
      logic [1:0]  source;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  app;
      logic [7:0]  layer;
      logic [15:0] from_code;
      logic [15:0] to_code;
   } entry_type;

   // entry moving along the cell row
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } flow_type;

   // per-cell search status
   typedef struct packed {
      logic [7:0]  slot_app;
      logic        hit;
      logic [15:0] hit_code;
   } cell_stat_type;

endpackage

// ===== rtl/core/priority_keycode_remap_table_core.sv =====
// ----------------------------------------------------------------------------
// priority_keycode_remap_table_core
// Keycode remap engine: table sweep through a row of slot cells.
// ----------------------------------------------------------------------------
// Writes take effect at the accepting edge; busy stays low.
// Fixed-position and out-of-range lookups: result strobed in the cycle after accept.
// Table lookups: the sweep reads N = min(entry_count, MAP_ENTRIES) entries, one entry per cycle,
// then the cell row drains and the resolve step walks slots down from the active count.
// One lookup at a time; the result strobe cannot be stalled.
// Reset clears state and counts and sets the transparent code to 1; table and slot contents are kept.
module priority_keycode_remap_table_core #(
   parameter int MAP_ENTRIES  = pkrt_pkg::MAP_ENTRIES_DEF,
   parameter int ACTIVE_SLOTS = pkrt_pkg::ACTIVE_SLOTS_DEF,
   parameter int LAYERS       = pkrt_pkg::LAYERS_DEF,
   parameter int COLUMNS      = pkrt_pkg::COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pkrt_pkg::req_type                   req,
   output logic                                rsp_valid,
   output pkrt_pkg::rsp_type                   rsp,
   input  logic                                csr_we,
   input  logic [pkrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pkrt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pkrt_pkg::*;

   localparam int AW   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int CW   = $clog2(MAP_ENTRIES + 1);
   localparam int SCW  = $clog2(ACTIVE_SLOTS + 1);
   localparam int SIW  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int DW   = $clog2(ACTIVE_SLOTS + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SWEEP   = 2'd1;
   localparam logic [1:0] ST_DRAIN   = 2'd2;
   localparam logic [1:0] ST_RESOLVE = 2'd3;

   logic [15:0]    noop_remap_ff;
   logic [15:0]    transparent_ff;
   logic [7:0]     app_count_ff;
   logic [8:0]     entry_count_ff;
   logic [SCW-1:0] active_count_ff;

   logic [1:0]     state_ff;
   logic [1:0]     state_in;
   logic [CW-1:0]  cnt_ff;
   logic [CW-1:0]  cnt_in;
   logic [CW-1:0]  n_ff;
   logic [CW-1:0]  n_in;
   logic [DW-1:0]  dcnt_ff;
   logic [DW-1:0]  dcnt_in;
   logic [SCW-1:0] s_ff;
   logic [SCW-1:0] s_in;
   logic [7:0]     key_layer_ff;
   logic [15:0]    key_code_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;

   logic           accept;
   logic [15:0]    req_code;
   logic           rd_en;
   logic           clear;
   logic [SCW-1:0] s_dec;
   logic [SIW-1:0] s_idx;
   cell_stat_type  sel_stat;
   logic [15:0]    miss_code;

   flow_type       flow [ACTIVE_SLOTS+1];
   cell_stat_type  stat [ACTIVE_SLOTS];

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign req_code = 16'(int'(req.row) * COLUMNS + int'(req.col));
   assign rd_en    = (state_ff == ST_SWEEP) && (cnt_ff != n_ff);
   assign clear    = accept && (req.op == OP_LOOKUP);

   pkrt_table #(
      .MAP_ENTRIES(MAP_ENTRIES),
      .AW         (AW)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept && (req.op == OP_WR_ENTRY) && (int'(req.index) < MAP_ENTRIES)),
      .wr_addr(AW'(req.index)),
      .wr_data({req.app, req.layer, req.from_code, req.to_code}),
      .rd_en  (rd_en),
      .rd_addr(cnt_ff[AW-1:0]),
      .rd_flow(flow[0])
   );

   for (genvar k = 0; k < ACTIVE_SLOTS; k++) begin : g_cell
      pkrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (accept && (req.op == OP_WR_SLOT) && (int'(req.index) == k)),
         .load_app (req.app),
         .clear    (clear),
         .key_layer(key_layer_ff),
         .key_code (key_code_ff),
         .flow_i   (flow[k]),
         .flow_o   (flow[k+1]),
         .stat     (stat[k])
      );
   end

   assign s_dec     = SCW'(s_ff - 1'b1);
   assign s_idx     = s_dec[SIW-1:0];
   assign sel_stat  = stat[s_idx];
   assign miss_code = (key_layer_ff == 8'd0) ? key_code_ff : transparent_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      dcnt_in      = dcnt_ff;
      s_in         = s_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.op == OP_LOOKUP)) begin
               if ((req.row == 4'd0) && (req.col == 4'd0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{keycode: noop_remap_ff, source: SRC_FIXED};
               end else if (int'(req.layer) >= LAYERS) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{keycode: req_code, source: SRC_RANGE};
               end else begin
                  state_in = ST_SWEEP;
                  cnt_in   = '0;
                  if (int'(entry_count_ff) > MAP_ENTRIES) begin
                     n_in = CW'(MAP_ENTRIES);
                  end else begin
                     n_in = CW'(entry_count_ff);
                  end
               end
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
               dcnt_in  = '0;
            end else begin
               cnt_in = CW'(cnt_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (int'(dcnt_ff) == ACTIVE_SLOTS) begin
               state_in = ST_RESOLVE;
               s_in     = active_count_ff;
            end else begin
               dcnt_in = DW'(dcnt_ff + 1'b1);
            end
         end
         ST_RESOLVE: begin
            // walk slots from the highest active one down
            if ((s_ff == '0) || (sel_stat.slot_app >= app_count_ff)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{keycode: miss_code, source: SRC_MISS};
            end else if (sel_stat.hit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{keycode: sel_stat.hit_code, source: SRC_HIT};
            end else begin
               s_in = s_dec;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         noop_remap_ff   <= '0;
         transparent_ff  <= 16'd1;
         app_count_ff    <= '0;
         entry_count_ff  <= '0;
         active_count_ff <= '0;
         cnt_ff          <= '0;
         n_ff            <= '0;
         dcnt_ff         <= '0;
         s_ff            <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         dcnt_ff      <= dcnt_in;
         s_ff         <= s_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NOOP_REMAP:  noop_remap_ff  <= csr_wdata;
               CSR_TRANSPARENT: transparent_ff <= csr_wdata;
               CSR_APP_COUNT:   app_count_ff   <= csr_wdata[7:0];
               CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
         if (accept && (req.op == OP_SET_COUNT)) begin
            if (int'(req.count) > ACTIVE_SLOTS) begin
               active_count_ff <= SCW'(ACTIVE_SLOTS);
            end else begin
               active_count_ff <= SCW'(req.count);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (clear) begin
         key_layer_ff <= req.layer;
         key_code_ff  <= req_code;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/pkrt_table.sv =====
// ----------------------------------------------------------------------------
// pkrt_table
// Remap entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pkrt_table #(
   parameter int MAP_ENTRIES = pkrt_pkg::MAP_ENTRIES_DEF,
   parameter int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pkrt_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output pkrt_pkg::flow_type  rd_flow
);
   import pkrt_pkg::*;

   entry_type mem [MAP_ENTRIES];
   entry_type rd_data_ff;
   logic      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_flow.valid = rd_valid_ff;
   assign rd_flow.entry = rd_data_ff;

endmodule

// ===== rtl/core/pkrt_cell.sv =====
// ----------------------------------------------------------------------------
// pkrt_cell
// One active slot: holds its application id, matches each passing entry
// and keeps the first hit. The entry moves on to the next cell.
// ----------------------------------------------------------------------------
module pkrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [7:0]              load_app,
   input  logic                    clear,
   input  logic [7:0]              key_layer,
   input  logic [15:0]             key_code,
   input  pkrt_pkg::flow_type      flow_i,
   output pkrt_pkg::flow_type      flow_o,
   output pkrt_pkg::cell_stat_type stat
);
   import pkrt_pkg::*;

   logic [7:0]  slot_app_ff;
   logic        hit_ff;
   logic        hit_in;
   logic [15:0] code_ff;
   logic [15:0] code_in;
   logic        flow_valid_ff;
   entry_type   flow_entry_ff;
   logic        match;

   assign match = flow_i.valid && !hit_ff
               && (flow_i.entry.app == slot_app_ff)
               && (flow_i.entry.layer == key_layer)
               && (flow_i.entry.from_code == key_code);

   always_comb begin
      hit_in  = hit_ff;
      code_in = code_ff;
      if (clear) begin
         hit_in = 1'b0;
      end else if (match) begin
         hit_in  = 1'b1;
         code_in = flow_i.entry.to_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         flow_valid_ff <= 1'b0;
      end else begin
         hit_ff        <= hit_in;
         flow_valid_ff <= flow_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_app_ff <= load_app;
      end
      code_ff       <= code_in;
      flow_entry_ff <= flow_i.entry;
   end

   assign flow_o.valid   = flow_valid_ff;
   assign flow_o.entry   = flow_entry_ff;
   assign stat.slot_app  = slot_app_ff;
   assign stat.hit       = hit_ff;
   assign stat.hit_code  = code_ff;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_keycode_remap_table_core. A behavioral
// copy of the remap engine tracks table, slot and register state and
// predicts every lookup. The bench runs store-free lookups from reset,
// fills the stores, runs a directed pass, then random phases under
// several register settings, all but one with random start idling.
// ----------------------------------------------------------------------------
module tb;
   import pkrt_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req       = '0;
   logic                  rsp_valid;
   rsp_type               rsp;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   priority_keycode_remap_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // shadow state of the engine
   entry_type   remap_tbl [MAP_ENTRIES_DEF];
   logic [7:0]  slot_app [ACTIVE_SLOTS_DEF];
   int          slot_cnt   = 0;
   logic [15:0] noop_reg   = 16'h0000;
   logic [15:0] transp_reg = 16'h0001;
   logic [7:0]  app_cnt    = 8'd0;
   logic [8:0]  entry_cnt  = 9'd0;

   rsp_type     pending_keys [$];
   rsp_type     want_key;
   int          errors      = 0;
   int          items_sent  = 0;
   int          hit_total   = 0;
   int          fixed_total = 0;
   int          range_total = 0;
   int          miss_total  = 0;
   int          idle_cycles = 0;
   logic        steady      = 1'b0;

   function automatic rsp_type lookup_key(input logic [7:0] layer, input logic [3:0] row,
                                          input logic [3:0] col);
      rsp_type     r;
      logic [15:0] code;
      int          n;
      int          s;
      int          i;
      logic        done;
      code = 16'(row * COLUMNS_DEF + col);
      n    = (entry_cnt > MAP_ENTRIES_DEF) ? MAP_ENTRIES_DEF : int'(entry_cnt);
      done = 1'b0;
      if (row == 4'd0 && col == 4'd0) begin
         r.keycode = noop_reg;
         r.source  = SRC_FIXED;
      end else if (layer >= LAYERS_DEF) begin
         r.keycode = code;
         r.source  = SRC_RANGE;
      end else begin
         r.keycode = (layer == 8'd0) ? code : transp_reg;
         r.source  = SRC_MISS;
         for (s = slot_cnt - 1; s >= 0 && !done; s--) begin
            if (slot_app[s] >= app_cnt) begin
               done = 1'b1;
            end else begin
               for (i = 0; i < n && !done; i++) begin
                  if (remap_tbl[i].app == slot_app[s] && remap_tbl[i].layer == layer &&
                      remap_tbl[i].from_code == code) begin
                     r.keycode = remap_tbl[i].to_code;
                     r.source  = SRC_HIT;
                     done      = 1'b1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   function automatic void track_request(input req_type it);
      case (it.op)
         OP_WR_ENTRY: begin
            remap_tbl[it.index] = '{it.app, it.layer, it.from_code, it.to_code};
         end
         OP_WR_SLOT: begin
            if (it.index < ACTIVE_SLOTS_DEF) slot_app[it.index] = it.app;
         end
         OP_SET_COUNT: begin
            slot_cnt = (it.count > ACTIVE_SLOTS_DEF) ? ACTIVE_SLOTS_DEF : int'(it.count);
         end
         default: begin
            pending_keys.push_back(lookup_key(it.layer, it.row, it.col));
         end
      endcase
   endfunction

   // one command transfer; start drops at random cycles unless steady
   task automatic send_item(input req_type it);
      logic go;
      req <= it;
      do begin
         go = steady || ($urandom_range(0, 99) >= 11);
         start <= go;
         @(posedge clock);
      end while (!(go && !busy));
      items_sent++;
      track_request(it);
   endtask

   function automatic logic [3:0] pick_rc();
      return ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
   endfunction

   function automatic req_type noise_item();
      req_type it;
      it.op        = 2'($urandom);
      it.layer     = 8'($urandom);
      it.row       = 4'($urandom);
      it.col       = 4'($urandom);
      it.index     = 8'($urandom);
      it.app       = 8'($urandom);
      it.from_code = 16'($urandom);
      it.to_code   = 16'($urandom);
      it.count     = 4'($urandom);
      return it;
   endfunction

   function automatic req_type rand_item();
      req_type it;
      int      sel;
      it  = noise_item();
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         it.op  = OP_LOOKUP;
         it.row = pick_rc();
         it.col = pick_rc();
         sel    = $urandom_range(0, 99);
         if (sel < 70) it.layer = 8'($urandom_range(0, 3));
         else if (sel < 88) it.layer = 8'($urandom_range(4, 15));
         else it.layer = 8'($urandom_range(16, 255));
      end else if (sel < 80) begin
         it.op = OP_WR_ENTRY;
         if ($urandom_range(0, 9) < 7) it.index = 8'($urandom_range(0, 47));
         if ($urandom_range(0, 99) < 85) it.app = 8'($urandom_range(0, 5));
         if ($urandom_range(0, 99) < 85) it.layer = 8'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 80) it.from_code = 16'(pick_rc() * COLUMNS_DEF + pick_rc());
      end else if (sel < 92) begin
         it.op = OP_WR_SLOT;
         if ($urandom_range(0, 99) < 85) it.index = 8'($urandom_range(0, 7));
         if ($urandom_range(0, 99) < 80) it.app = 8'($urandom_range(0, 5));
      end else begin
         it.op = OP_SET_COUNT;
         if ($urandom_range(0, 9) < 7) it.count = 4'($urandom_range(1, 8));
      end
      return it;
   endfunction

   task automatic do_lookup(input logic [7:0] layer, input logic [3:0] row,
                            input logic [3:0] col);
      req_type it;
      it       = noise_item();
      it.op    = OP_LOOKUP;
      it.layer = layer;
      it.row   = row;
      it.col   = col;
      send_item(it);
   endtask

   task automatic do_entry(input logic [7:0] index, input logic [7:0] app,
                           input logic [7:0] layer, input logic [15:0] from_code,
                           input logic [15:0] to_code);
      req_type it;
      it           = noise_item();
      it.op        = OP_WR_ENTRY;
      it.index     = index;
      it.app       = app;
      it.layer     = layer;
      it.from_code = from_code;
      it.to_code   = to_code;
      send_item(it);
   endtask

   task automatic do_slot(input logic [7:0] index, input logic [7:0] app);
      req_type it;
      it       = noise_item();
      it.op    = OP_WR_SLOT;
      it.index = index;
      it.app   = app;
      send_item(it);
   endtask

   task automatic do_count(input logic [3:0] count);
      req_type it;
      it       = noise_item();
      it.op    = OP_SET_COUNT;
      it.count = count;
      send_item(it);
   endtask

   // drop start and let every pending lookup come back
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_NOOP_REMAP:  noop_reg   = val;
         CSR_TRANSPARENT: transp_reg = val;
         CSR_APP_COUNT:   app_cnt    = val[7:0];
         default:         entry_cnt  = val[8:0];
      endcase
   endtask

   task automatic set_regs(input logic [15:0] noop, input logic [15:0] transp,
                           input logic [15:0] apps, input logic [15:0] entries);
      wait_idle();
      write_csr(CSR_NOOP_REMAP, noop);
      write_csr(CSR_TRANSPARENT, transp);
      write_csr(CSR_APP_COUNT, apps);
      write_csr(CSR_ENTRY_COUNT, entries);
      csr_we <= 1'b0;
   endtask

   // reset values, no store is read: zero active slots
   task automatic test_reset_lookups();
      do_lookup(8'd0, 4'd0, 4'd0);
      do_lookup(8'd16, 4'd9, 4'd4);
      do_lookup(8'd0, 4'd5, 4'd7);
      do_lookup(8'd3, 4'd15, 4'd15);
   endtask

   task automatic test_fill_stores();
      req_type it;
      int      k;
      for (k = 0; k < MAP_ENTRIES_DEF; k++) begin
         do begin
            it = rand_item();
         end while (it.op != OP_WR_ENTRY);
         it.index = 8'(k);
         send_item(it);
      end
      for (k = 0; k < ACTIVE_SLOTS_DEF; k++) do_slot(8'(k), 8'($urandom_range(0, 5)));
   endtask

   task automatic test_directed();
      set_regs(16'hFFFF, 16'h0000, 16'd255, 16'd16);
      do_entry(8'd0, 8'd5, 8'd2, 16'h0021, 16'hBEEF);
      do_entry(8'd1, 8'd5, 8'd2, 16'h0021, 16'hDEAD);
      do_entry(8'd2, 8'd6, 8'd2, 16'h0021, 16'h1234);
      do_entry(8'd255, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      do_slot(8'd0, 8'd5);
      do_slot(8'd1, 8'd6);
      do_slot(8'd9, 8'd0);
      do_slot(8'd255, 8'd255);
      do_count(4'd1);
      do_lookup(8'd2, 4'd2, 4'd1);
      do_count(4'd2);
      do_lookup(8'd2, 4'd2, 4'd1);
      do_lookup(8'd2, 4'd0, 4'd0);
      do_lookup(8'd16, 4'd15, 4'd15);
      do_lookup(8'd255, 4'd15, 4'd15);
      do_lookup(8'd2, 4'd3, 4'd3);
      do_lookup(8'd0, 4'd3, 4'd3);
      do_slot(8'd1, 8'd255);
      do_lookup(8'd2, 4'd2, 4'd1);
      do_count(4'd15);
      do_lookup(8'd2, 4'd2, 4'd1);
      do_count(4'd0);
      do_lookup(8'd2, 4'd2, 4'd1);
   endtask

   task automatic test_random_phase(input logic [15:0] noop, input logic [15:0] transp,
                                    input logic [15:0] apps, input logic [15:0] entries,
                                    input logic quiet, input int n);
      set_regs(noop, transp, apps, entries);
      steady = quiet;
      repeat (n) send_item(rand_item());
      steady = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lookups();
      test_fill_stores();
      test_directed();
      test_random_phase(16'h0000, 16'hFFFF, 16'd6, 16'd32, 1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'd4, 16'd64, 1'b1, 170);
      test_random_phase(16'hFFFF, 16'h0000, 16'd255, 16'd256, 1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'd0, 16'd48, 1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'd3, 16'd0, 1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'd6, 16'hFFFF, 1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 8)), 16'd24,
                        1'b0, 170);
      test_random_phase(16'($urandom), 16'($urandom), 16'd5, 16'd300, 1'b0, 170);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += pending_keys.size();
      $display("summary: %0d command transfers, %0d lookups checked", items_sent,
               hit_total + fixed_total + range_total + miss_total);
      $display("summary: %0d table hits, %0d fixed position, %0d layer out of range, %0d defaults",
               hit_total, fixed_total, range_total, miss_total);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_keys.size() == 0) begin
            $display("%0t: unexpected result transfer keycode=%h source=%0d", $time,
                     rsp.keycode, rsp.source);
            errors++;
         end else begin
            want_key = pending_keys.pop_front();
            case (want_key.source)
               SRC_HIT:   hit_total++;
               SRC_FIXED: fixed_total++;
               SRC_RANGE: range_total++;
               default:   miss_total++;
            endcase
            if (rsp.keycode !== want_key.keycode) begin
               $display("%0t: keycode mismatch expected=%h actual=%h", $time,
                        want_key.keycode, rsp.keycode);
               errors++;
            end
            if (rsp.source !== want_key.source) begin
               $display("%0t: source mismatch expected=%0d actual=%0d", $time,
                        want_key.source, rsp.source);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule

// ===== files.f =====
rtl/core/pkrt_pkg.sv
rtl/core/pkrt_table.sv
rtl/core/pkrt_cell.sv
rtl/core/priority_keycode_remap_table_core.sv
sim/tb.sv
